// ===== rtl/ramped_fractional_delay_line_assert.svh =====
// Assertion macros shared by the delay line RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef RAMPED_FRACTIONAL_DELAY_LINE_ASSERT_SVH
`define RAMPED_FRACTIONAL_DELAY_LINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFDL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RFDL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rfdl_pkg.sv =====
`default_nettype none

package rfdl_pkg;

    // Field and storage widths.
    localparam int SAMPLE_BITS    = 24;
    localparam int ADDR_BITS      = 16;
    localparam int DELAY_BITS     = 24;
    localparam int FRAC_BITS      = 8;
    localparam int GAIN_BITS      = 18;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int PADDR_BITS     = 3;
    localparam int PDATA_BITS     = 32;

    // Derived widths of the arithmetic.
    localparam int INTERP_BITS = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int SCALED_BITS = PROD_BITS - GAIN_FRAC_BITS;

    // Numeric constants.
    localparam logic [DELAY_BITS-1:0] ONE_SAMPLE = DELAY_BITS'(1 << FRAC_BITS);
    localparam logic [GAIN_BITS-1:0]  GAIN_RESET = GAIN_BITS'(1 << GAIN_FRAC_BITS);
    localparam logic signed [INTERP_BITS-1:0] INTERP_ROUND =
        INTERP_BITS'(1 << (FRAC_BITS - 1));
    localparam logic signed [PROD_BITS-1:0] GAIN_ROUND =
        PROD_BITS'(1 << (GAIN_FRAC_BITS - 1));
    localparam logic signed [SAMPLE_BITS-1:0] RANGE_LIMIT =
        SAMPLE_BITS'(10 << (SAMPLE_BITS - 5));
    localparam logic signed [SAMPLE_BITS-1:0] RANGE_LOW = -RANGE_LIMIT;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX =
        {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN =
        {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Register indexes on the configuration port.
    typedef enum logic
    {
        REG_TARGET = 1'b0,
        REG_GAIN   = 1'b1
    } reg_idx_t;

    // Configuration seen by the datapath.
    typedef struct packed
    {
        logic [DELAY_BITS-1:0] target;
        logic [GAIN_BITS-1:0]  gain;
        logic                  target_write;
        logic [DELAY_BITS-1:0] target_data;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic take_input;
        logic ramp;
        logic pass_load;
        logic rd_a;
        logic rd_b;
        logic chk_a;
        logic chk_b;
        logic interp;
        logic gain_mul;
        logic sat;
        logic store_write;
        logic clear_step;
        logic out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed
    {
        logic ramp_zero;
        logic clr_last;
        logic fault;
        logic out_free;
    } dp_status_t;

    // One step of the delay toward the target, snapping within one sample.
    function automatic logic [DELAY_BITS-1:0] ramp_step(
        input logic [DELAY_BITS-1:0] cur,
        input logic [DELAY_BITS-1:0] tgt
    );
        logic [DELAY_BITS-1:0] res;
        res = cur;
        if (cur < tgt)
        begin
            if ((tgt - cur) > ONE_SAMPLE)
                res = cur + ONE_SAMPLE;
            else
                res = tgt;
        end
        else if (cur > tgt)
        begin
            if ((cur - tgt) > ONE_SAMPLE)
                res = cur - ONE_SAMPLE;
            else
                res = tgt;
        end
        return res;
    endfunction

    // A stored sample is valid inside (-10, 10].
    function automatic logic in_range(input logic signed [SAMPLE_BITS-1:0] s);
        return (s > RANGE_LOW) && (s <= RANGE_LIMIT);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rfdl_regs.sv =====
`default_nettype none

module rfdl_regs
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [rfdl_pkg::PADDR_BITS-1:0]    paddr,
    input  wire logic [rfdl_pkg::PDATA_BITS-1:0]    pwdata,
    output logic      [rfdl_pkg::PDATA_BITS-1:0]    prdata,
    output logic                                    pready,
    output rfdl_pkg::cfg_t                          cfg
);
    import rfdl_pkg::*;

    logic [DELAY_BITS-1:0] target_reg;
    logic [GAIN_BITS-1:0]  gain_reg;
    reg_idx_t              idx;
    logic                  wr_en;

    // Registers sit on 32-bit word addresses.
    assign idx    = reg_idx_t'(paddr[PADDR_BITS-1]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            gain_reg   <= GAIN_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_TARGET: target_reg <= pwdata[DELAY_BITS-1:0];
                REG_GAIN:   gain_reg   <= pwdata[GAIN_BITS-1:0];
            endcase
        end
    end

    // Read data.
    always_comb
    begin
        unique case (idx)
            REG_TARGET: prdata = PDATA_BITS'(target_reg);
            REG_GAIN:   prdata = PDATA_BITS'(gain_reg);
        endcase
    end

    // The datapath loads a new target directly when the delay is zero.
    assign cfg.target       = target_reg;
    assign cfg.gain         = gain_reg;
    assign cfg.target_write = wr_en && (idx == REG_TARGET);
    assign cfg.target_data  = pwdata[DELAY_BITS-1:0];

endmodule

`default_nettype wire

// ===== rtl/rfdl_ctrl.sv =====
`default_nettype none

module rfdl_ctrl
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire rfdl_pkg::dp_status_t   status,
    output rfdl_pkg::dp_cmd_t           cmd
);
    import rfdl_pkg::*;

    typedef enum logic [3:0]
    {
        S_INIT,
        S_IDLE,
        S_RAMP1,
        S_RAMP2,
        S_RDA,
        S_RDB,
        S_CHKB,
        S_INTERP,
        S_GAIN,
        S_SAT,
        S_FLUSH,
        S_WRITE,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.clear_step = 1'b1;
                if (status.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_input = 1'b1;
                    state_next     = S_RAMP1;
                end
            end
            S_RAMP1:
            begin
                cmd.ramp = 1'b1;
                if (status.ramp_zero)
                begin
                    cmd.pass_load = 1'b1;
                    state_next    = S_GAIN;
                end
                else
                begin
                    state_next = S_RAMP2;
                end
            end
            S_RAMP2:
            begin
                cmd.ramp   = 1'b1;
                state_next = S_RDA;
            end
            S_RDA:
            begin
                cmd.rd_a   = 1'b1;
                state_next = S_RDB;
            end
            S_RDB:
            begin
                cmd.rd_b   = 1'b1;
                cmd.chk_a  = 1'b1;
                state_next = S_CHKB;
            end
            S_CHKB:
            begin
                cmd.chk_b  = 1'b1;
                state_next = S_INTERP;
            end
            S_INTERP:
            begin
                cmd.interp = 1'b1;
                state_next = S_GAIN;
            end
            S_GAIN:
            begin
                cmd.gain_mul = 1'b1;
                state_next   = S_SAT;
            end
            S_SAT:
            begin
                cmd.sat = 1'b1;
                if (status.fault)
                    state_next = S_FLUSH;
                else
                    state_next = S_WRITE;
            end
            S_FLUSH:
            begin
                cmd.clear_step = 1'b1;
                if (status.clr_last)
                    state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.store_write = 1'b1;
                state_next      = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // A new word is taken only between items.
    assign in_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/rfdl_datapath.sv =====
`default_nettype none
`include "ramped_fractional_delay_line_assert.svh"

module rfdl_datapath
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire rfdl_pkg::cfg_t                         cfg,
    input  wire rfdl_pkg::dp_cmd_t                      cmd,
    output rfdl_pkg::dp_status_t                        status,
    input  wire logic signed [rfdl_pkg::SAMPLE_BITS-1:0] sample_in,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic signed [rfdl_pkg::SAMPLE_BITS-1:0]     sample_out,
    output logic                                        range_fault
);
    import rfdl_pkg::*;

    // Sample store, one write and one registered read per cycle.
    logic signed [SAMPLE_BITS-1:0] store_mem [(1 << ADDR_BITS)];
    logic                          mem_we;
    logic [ADDR_BITS-1:0]          mem_waddr;
    logic signed [SAMPLE_BITS-1:0] mem_wdata;
    logic                          mem_re;
    logic [ADDR_BITS-1:0]          mem_raddr;
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [DELAY_BITS-1:0]         cur_reg;
    logic [DELAY_BITS-1:0]         ramp_next;
    logic [ADDR_BITS-1:0]          wp_reg;
    logic [ADDR_BITS-1:0]          ra_reg;
    logic [ADDR_BITS-1:0]          ra_next;
    logic [ADDR_BITS-1:0]          clr_addr_reg;
    logic signed [SAMPLE_BITS-1:0] a_reg;
    logic signed [SAMPLE_BITS-1:0] b_reg;
    logic                          fault_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [SAMPLE_BITS-1:0] sat_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;
    logic                          range_fault_reg;

    logic signed [SAMPLE_BITS:0]   interp_diff;
    logic signed [FRAC_BITS:0]     interp_frac;
    logic signed [INTERP_BITS-1:0] interp_prod;
    logic signed [INTERP_BITS-1:0] interp_sum;
    logic signed [SAMPLE_BITS-1:0] interp_y;
    logic signed [GAIN_BITS:0]     gain_s;
    logic signed [PROD_BITS-1:0]   round_sum;
    logic signed [SCALED_BITS-1:0] scaled;
    logic signed [SAMPLE_BITS-1:0] sat_next;

    // Delay ramp and read address of the newer sample.
    assign ramp_next = ramp_step(cur_reg, cfg.target);
    assign ra_next   = wp_reg - cur_reg[FRAC_BITS +: ADDR_BITS];

    // Store port selection: the flush sweep writes zeros, otherwise the input word.
    assign mem_we    = cmd.store_write || cmd.clear_step;
    assign mem_waddr = cmd.clear_step ? clr_addr_reg : wp_reg;
    assign mem_wdata = cmd.clear_step ? '0 : x_reg;
    assign mem_re    = cmd.rd_a || cmd.rd_b;
    assign mem_raddr = cmd.rd_a ? ra_next : (ra_reg - 1'b1);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= store_mem[mem_raddr];
    end

    // Control registers: delay, pointers, fault flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg      <= '0;
            wp_reg       <= '0;
            clr_addr_reg <= '0;
            fault_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.target_write && (cur_reg == '0))
                cur_reg <= cfg.target_data;
            else if (cmd.ramp)
                cur_reg <= ramp_next;

            if (cmd.clear_step)
                wp_reg <= '0;
            else if (cmd.store_write)
                wp_reg <= wp_reg + 1'b1;

            if (cmd.clear_step)
                clr_addr_reg <= clr_addr_reg + 1'b1;

            if (cmd.take_input)
                fault_reg <= 1'b0;
            else if (cmd.chk_a && !in_range(rd_data_reg))
                fault_reg <= 1'b1;
            else if (cmd.chk_b && !in_range(rd_data_reg))
                fault_reg <= 1'b1;
        end
    end

    // Linear interpolation: y = a + (b - a) * F / 256, rounded.
    assign interp_diff = (SAMPLE_BITS+1)'(b_reg) - (SAMPLE_BITS+1)'(a_reg);
    assign interp_frac = $signed({1'b0, cur_reg[FRAC_BITS-1:0]});
    assign interp_prod = INTERP_BITS'(interp_diff * interp_frac);
    assign interp_sum  = (INTERP_BITS'(a_reg) <<< FRAC_BITS) + interp_prod + INTERP_ROUND;
    assign interp_y    = interp_sum[FRAC_BITS +: SAMPLE_BITS];

    // Gain rounding and saturation.
    assign gain_s    = $signed({1'b0, cfg.gain});
    assign round_sum = prod_reg + GAIN_ROUND;
    assign scaled    = round_sum[GAIN_FRAC_BITS +: SCALED_BITS];

    always_comb
    begin
        priority if (scaled > SCALED_BITS'(SAMPLE_MAX))
            sat_next = SAMPLE_MAX;
        else if (scaled < SCALED_BITS'(SAMPLE_MIN))
            sat_next = SAMPLE_MIN;
        else
            sat_next = scaled[SAMPLE_BITS-1:0];
    end

    // Payload registers along the item's path.
    always_ff @(posedge clk)
    begin
        if (cmd.take_input)
            x_reg <= sample_in;
        if (cmd.rd_a)
            ra_reg <= ra_next;
        if (cmd.chk_a)
            a_reg <= in_range(rd_data_reg) ? rd_data_reg : '0;
        // After a flush on the newer sample the store reads as zero.
        if (cmd.chk_b)
            b_reg <= (fault_reg || !in_range(rd_data_reg)) ? '0 : rd_data_reg;
        if (cmd.pass_load)
            y_reg <= x_reg;
        else if (cmd.interp)
            y_reg <= interp_y;
        if (cmd.gain_mul)
            prod_reg <= PROD_BITS'(y_reg * gain_s);
        if (cmd.sat)
            sat_reg <= sat_next;
        if (cmd.out_load)
        begin
            sample_out_reg  <= sat_reg;
            range_fault_reg <= fault_reg;
        end
    end

    // Output word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid   = out_valid_reg;
    assign sample_out  = sample_out_reg;
    assign range_fault = range_fault_reg;

    // Status back to the controller.
    assign status.ramp_zero = (ramp_next == '0);
    assign status.clr_last  = (clr_addr_reg == '1);
    assign status.fault     = fault_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;

    // After a flush the input word lands at entry zero.
    `RFDL_ASSERT_SAME(a_flush_ptr, cmd.store_write && fault_reg, wp_reg == '0, "write after flush not at entry zero")
    // The output register is never overwritten while a word waits.
    `RFDL_ASSERT_SAME(a_out_free, cmd.out_load, !out_valid_reg || !out_stall, "output word overwritten")
    // A loaded word is presented with the saturated result.
    `RFDL_ASSERT_NEXT(a_out_load, cmd.out_load, out_valid_reg && (sample_out_reg == $past(sat_reg)), "output word not presented")
    // The pass-through path never reports a fault.
    `RFDL_ASSERT_SAME(a_pass_clean, cmd.pass_load, !fault_reg, "fault on pass-through")
    // A flush on the newer sample forces the older one to zero.
    `RFDL_ASSERT_NEXT(a_b_zero, cmd.chk_b && fault_reg, b_reg == '0, "older sample read after flush")

endmodule

`default_nettype wire

// ===== rtl/ramped_fractional_delay_line.sv =====
`default_nettype none

// Mono fractional delay line with a 65536-word store, linear interpolation and
// a Q2.16 output gain. After reset the block clears its whole store before
// taking the first word. A word is taken only after the previous one has been
// loaded into the output register. The controller sequences each word over the
// store (two reads and one write per word on the delayed path, one write on the
// zero-delay path) and the interpolation and gain multipliers. A stored sample
// out of range triggers a flush of the whole store before the result is
// presented. The output register lets a finished word wait while the next input
// is accepted. Configuration must be written only between words; the block
// itself does not enforce this.
module ramped_fractional_delay_line
(
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    output logic                                         in_stall,
    input  wire logic signed [rfdl_pkg::SAMPLE_BITS-1:0] sample_in,
    output logic                                         out_valid,
    input  wire logic                                    out_stall,
    output logic signed [rfdl_pkg::SAMPLE_BITS-1:0]      sample_out,
    output logic                                         range_fault,
    input  wire logic                                    psel,
    input  wire logic                                    penable,
    input  wire logic                                    pwrite,
    input  wire logic [rfdl_pkg::PADDR_BITS-1:0]         paddr,
    input  wire logic [rfdl_pkg::PDATA_BITS-1:0]         pwdata,
    output logic      [rfdl_pkg::PDATA_BITS-1:0]         prdata,
    output logic                                         pready
);
    import rfdl_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    // Configuration registers.
    rfdl_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer.
    rfdl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Store, arithmetic and output register.
    rfdl_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .status      (status),
        .sample_in   (sample_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample_out  (sample_out),
        .range_fault (range_fault)
    );

endmodule

`default_nettype wire

// ===== dv/delay_line_checker.sv =====
`timescale 1ns / 1ps

module delay_line_checker
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic                                    in_stall,
    input  logic signed [rfdl_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic                                    out_valid,
    input  logic                                    out_stall,
    input  logic signed [rfdl_pkg::SAMPLE_BITS-1:0] sample_out,
    input  logic                                    range_fault,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [rfdl_pkg::PADDR_BITS-1:0]         paddr,
    input  logic [rfdl_pkg::PDATA_BITS-1:0]         pwdata,
    input  logic                                    pready,
    output int                                      words_in_flight,
    output int                                      mismatch_count
);
    import rfdl_pkg::*;

    // One predicted output word.
    typedef struct packed
    {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          fault;
    } delayed_word_t;

    // Mirror of the block's configuration and delay state.
    logic [DELAY_BITS-1:0]         target_delay;
    logic [DELAY_BITS-1:0]         live_delay;
    logic [GAIN_BITS-1:0]          gain;
    logic [ADDR_BITS-1:0]          write_ptr;
    logic signed [SAMPLE_BITS-1:0] history [bit [ADDR_BITS-1:0]];
    delayed_word_t                 expected_words [$];
    delayed_word_t                 oldest;

    // Moves the delay one sample toward the target, landing on it when close.
    function automatic logic [DELAY_BITS-1:0] step_toward(
        input logic [DELAY_BITS-1:0] cur,
        input logic [DELAY_BITS-1:0] tgt
    );
        logic [DELAY_BITS-1:0] gap;
        if (cur == tgt)
            return cur;
        gap = (cur < tgt) ? tgt - cur : cur - tgt;
        if (gap <= ONE_SAMPLE)
            return tgt;
        return (cur < tgt) ? cur + ONE_SAMPLE : cur - ONE_SAMPLE;
    endfunction

    // Entries never written since the last clear read as zero.
    function automatic longint stored_level(input logic [ADDR_BITS-1:0] idx);
        if (history.exists(idx))
            return longint'(history[idx]);
        return 0;
    endfunction

    function automatic bit level_ok(input longint s);
        longint lim;
        lim = longint'(RANGE_LIMIT);
        return (s > -lim) && (s <= lim);
    endfunction

    // Works out the output word for one input word and updates the mirror.
    function automatic delayed_word_t predict_delayed_word(
        input logic signed [SAMPLE_BITS-1:0] x
    );
        delayed_word_t         res;
        longint                a;
        longint                b;
        longint                y;
        longint                scaled;
        logic [ADDR_BITS-1:0]  ra;
        logic [ADDR_BITS-1:0]  rb;
        logic [FRAC_BITS-1:0]  frac;
        res.fault = 1'b0;
        live_delay = step_toward(live_delay, target_delay);
        if (live_delay == '0)
        begin
            y = longint'(x);
        end
        else
        begin
            live_delay = step_toward(live_delay, target_delay);
            frac = live_delay[FRAC_BITS-1:0];
            ra = write_ptr - live_delay[DELAY_BITS-1:FRAC_BITS];
            rb = ra - 1'b1;
            // A bad level on either tap empties the store and restarts the pointer.
            a = stored_level(ra);
            if (!level_ok(a))
            begin
                a = 0;
                history.delete();
                write_ptr = '0;
                res.fault = 1'b1;
            end
            b = stored_level(rb);
            if (!level_ok(b))
            begin
                b = 0;
                history.delete();
                write_ptr = '0;
                res.fault = 1'b1;
            end
            y = (a * (longint'(256) - longint'(frac)) + b * longint'(frac) + 128) >>> 8;
        end
        history[write_ptr] = x;
        write_ptr = write_ptr + 1'b1;

        // Gain with rounding, then clamp to the sample range.
        scaled = (y * longint'(gain) + 32768) >>> 16;
        if (scaled > longint'(SAMPLE_MAX))
            scaled = longint'(SAMPLE_MAX);
        if (scaled < longint'(SAMPLE_MIN))
            scaled = longint'(SAMPLE_MIN);
        res.sample = scaled[SAMPLE_BITS-1:0];
        return res;
    endfunction

    // Register writes, output comparison and prediction, in that order.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_delay = '0;
            live_delay = '0;
            gain = GAIN_RESET;
            write_ptr = '0;
            history.delete();
            expected_words.delete();
            words_in_flight <= 0;
            mismatch_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == PADDR_BITS'({REG_TARGET, 2'b00}))
                begin
                    target_delay = pwdata[DELAY_BITS-1:0];
                    if (live_delay == '0)
                        live_delay = target_delay;
                end
                else if (paddr == PADDR_BITS'({REG_GAIN, 2'b00}))
                begin
                    gain = pwdata[GAIN_BITS-1:0];
                end
            end

            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected output word: sample_out %0d, range_fault %0b",
                        sample_out, range_fault);
                    mismatch_count++;
                end
                else
                begin
                    oldest = expected_words.pop_front();
                    if (sample_out !== oldest.sample)
                    begin
                        $error("sample_out mismatch: expected %0d, actual %0d",
                            oldest.sample, sample_out);
                        mismatch_count++;
                    end
                    if (range_fault !== oldest.fault)
                    begin
                        $error("range_fault mismatch: expected %0b, actual %0b",
                            oldest.fault, range_fault);
                        mismatch_count++;
                    end
                end
            end

            if (in_valid && !in_stall)
                expected_words.push_back(predict_delayed_word(sample_in));

            words_in_flight <= expected_words.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import rfdl_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int PHASE_WORDS = 225;
    localparam int HOLD_CYCLES = 500;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic signed [SAMPLE_BITS-1:0] sample_in = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          range_fault;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [PADDR_BITS-1:0]         paddr = '0;
    logic [PDATA_BITS-1:0]         pwdata = '0;
    logic [PDATA_BITS-1:0]         prdata;
    logic                          pready;

    int words_in_flight;
    int mismatch_count;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    bit hold_arm = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int bad_levels_left = 4;

    always #10 clk = ~clk;

    ramped_fractional_delay_line uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample_in   (sample_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample_out  (sample_out),
        .range_fault (range_fault),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    delay_line_checker checker_i
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .sample_in       (sample_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .sample_out      (sample_out),
        .range_fault     (range_fault),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .words_in_flight (words_in_flight),
        .mismatch_count  (mismatch_count)
    );

    // Give up on a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Output back-pressure: one long hold when armed, random stalls otherwise.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_arm && !hold_done)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Register write: setup phase, access phase until pready, then the bus goes idle.
    task automatic reg_write(input reg_idx_t idx, input logic [PDATA_BITS-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_BITS'({idx, 2'b00});
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one word after a random idle gap and waits until it is taken.
    task automatic send_word(input logic signed [SAMPLE_BITS-1:0] x);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        sample_in <= x;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Stops offering and waits for every predicted word to come out.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (words_in_flight != 0);
    endtask

    // Mostly legal levels; a handful of out-of-range ones keep the flush rare.
    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        int v;
        if (bad_levels_left > 0 && $urandom_range(199) == 0)
        begin
            bad_levels_left--;
            if ($urandom_range(1) == 1)
                v = int'($urandom_range(8388607, 5242881));
            else
                v = -int'($urandom_range(8388608, 5242880));
        end
        else
        begin
            v = int'($urandom_range(10485759)) - 5242879;
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    task automatic random_phase(input int send_pct, input int recv_pct, input bit pause_mid);
        send_idle_pct = send_pct;
        stall_pct <= recv_pct;
        for (int i = 0; i < PHASE_WORDS; i++)
        begin
            if (pause_mid && i == PHASE_WORDS / 2)
                settle();
            send_word(random_sample());
        end
        settle();
    endtask

    initial
    begin
        int pass_words[$];
        int tap_words[$];
        int loud_words[$];
        pass_words = '{0, 8388607, -8388608, 5242880, -5242880, -5242879, 4194304,
                       -1, 1, -6000000, 50};
        tap_words = '{7, 20, 6000000, 30, 40};
        loud_words = '{5242880, 5242880, -5242879, -5242879, 1000, -1000};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Zero delay: extremes and range edges pass straight through.
        reg_write(REG_TARGET, 0);
        reg_write(REG_GAIN, 32'd65536);
        foreach (pass_words[i])
            send_word(pass_words[i][SAMPLE_BITS-1:0]);
        settle();

        // One-sample delay loaded at once: bad level on the older tap, then on
        // the newer tap.
        reg_write(REG_TARGET, 32'h100);
        foreach (tap_words[i])
            send_word(tap_words[i][SAMPLE_BITS-1:0]);
        settle();

        // Half-sample fraction with the largest gain, so the output clamps.
        reg_write(REG_GAIN, 32'd262143);
        reg_write(REG_TARGET, 32'h180);
        foreach (loud_words[i])
            send_word(loud_words[i][SAMPLE_BITS-1:0]);
        settle();

        // Random phases across delays, gains and idling patterns.
        reg_write(REG_TARGET, 0);
        reg_write(REG_GAIN, $urandom_range(262143));
        random_phase(0, 0, 1'b0);

        reg_write(REG_TARGET, $urandom_range(64 * 256));
        reg_write(REG_GAIN, 0);
        random_phase(64, 0, 1'b0);

        reg_write(REG_TARGET, $urandom_range(300 * 256));
        reg_write(REG_GAIN, $urandom_range(262143));
        random_phase(0, 64, 1'b0);

        reg_write(REG_TARGET, $urandom_range(64 * 256));
        reg_write(REG_GAIN, 32'd262143);
        random_phase(36, 36, 1'b0);

        // Ramp back to zero delay while the output is held off for a while.
        reg_write(REG_TARGET, 0);
        reg_write(REG_GAIN, 32'd65536);
        hold_arm <= 1'b1;
        random_phase(0, 0, 1'b0);

        // Longest whole-sample delay, loaded at once when the ramp has reached zero.
        reg_write(REG_TARGET, 32'hFFFF00);
        reg_write(REG_GAIN, $urandom_range(262143));
        random_phase(64, 0, 1'b0);

        reg_write(REG_TARGET, $urandom_range(16776960));
        reg_write(REG_GAIN, $urandom_range(262143));
        random_phase(0, 64, 1'b0);

        reg_write(REG_TARGET, $urandom_range(16 * 256));
        reg_write(REG_GAIN, $urandom_range(262143));
        random_phase(36, 36, 1'b1);

        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && words_in_flight == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
